// ----- hw/rtl/rv32_pkg.sv -----
// rv32_pkg: opcodes, widths and shared types of the execute unit
// no dependencies
package rv32_pkg;
  localparam int XLEN = 32;
  localparam int OP_W = 6;
  localparam int REG_IDX_W = 4;

  localparam logic [OP_W-1:0] OP_ADD = 6'd0, OP_ADDI = 6'd1, OP_SUB = 6'd2,
    OP_LUI = 6'd3, OP_AUIPC = 6'd4, OP_XOR = 6'd5, OP_XORI = 6'd6, OP_OR = 6'd7,
    OP_ORI = 6'd8, OP_AND = 6'd9, OP_ANDI = 6'd10, OP_SLT = 6'd11, OP_SLTI = 6'd12,
    OP_SLTU = 6'd13, OP_SLTIU = 6'd14, OP_SLL = 6'd15, OP_SLLI = 6'd16,
    OP_SRL = 6'd17, OP_SRLI = 6'd18, OP_SRA = 6'd19, OP_SRAI = 6'd20,
    OP_BEQ = 6'd21, OP_BNE = 6'd22, OP_BLT = 6'd23, OP_BGE = 6'd24,
    OP_BLTU = 6'd25, OP_BGEU = 6'd26, OP_JAL = 6'd27, OP_JALR = 6'd28,
    OP_MUL = 6'd29, OP_MULH = 6'd30, OP_MULHSU = 6'd31, OP_MULHU = 6'd32,
    OP_DIV = 6'd33, OP_DIVU = 6'd34, OP_REM = 6'd35, OP_REMU = 6'd36;

  localparam logic [XLEN-1:0] UPPER_MASK = 32'hFFFF_F000;

  typedef struct packed {
    logic [OP_W-1:0]      opcode;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] src1_reg;
    logic [REG_IDX_W-1:0] src2_reg;
    logic signed [XLEN-1:0] immediate;
  } instr_t;

  typedef struct packed {
    logic                   write_enable;
    logic signed [XLEN-1:0] write_value;
    logic [XLEN-1:0]        next_pc;
    logic                   branch_taken;
  } result_t;
endpackage

// ----- hw/rtl/rv32_stream_if.sv -----
// rv32_stream_if: valid/ready channel carrying one packed item
// depends on nothing; the payload type is the parameter T
interface rv32_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rv32im_execute_unit.sv -----
// rv32im_execute_unit: sequenced integer execute unit with register file
// depends on rv32_pkg and rv32_stream_if
//
// usage:
//   instr (sink) takes one decoded instruction item; result (source) gives
//   one item per instruction: write flag, written value, next word pc and
//   whether flow was redirected.
//   the unit works on one item at a time. after acceptance the S_READ state reads
//   the operands, then one of:
//     simple ops (alu, shifts, branches, jumps): the S_EXEC state
//     mul family: a radix-2 shift-and-add over 32 steps, then the S_FIX finish state
//     div/rem: a restoring radix-2 divider, 32 steps, then the S_FIX sign-fix state
//   the result is valid in the cycle after that. the 32-step loops on the
//   single shared adder make mul/div/rem the long case.
//   the result sits in an output register; the unit accepts the next item
//   once that register has been taken, so a stalled receiver stalls input.
//   reset clears the register file (16 flip-flop words), the pc and the
//   state register; the unit is ready in the first cycle after reset.
//   register 0 reads zero and writes to it are dropped.
module rv32im_execute_unit #(
  parameter int NUM_REGS = 16
) (
  input  logic clk,
  input  logic rst,
  rv32_stream_if.sink   instr,
  rv32_stream_if.source result
);
  import rv32_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_EXEC = 3'd2,
                         S_MUL = 3'd3, S_DIV = 3'd4, S_FIX = 3'd5, S_OUT = 3'd6;

  logic [2:0] state;
  logic [XLEN-1:0] regs [NUM_REGS];
  logic [XLEN-1:0] pc;
  instr_t cur;
  logic [XLEN-1:0] a, b;
  // multiply / divide working registers
  logic [XLEN-1:0] acc;     // product high / remainder
  logic [XLEN-1:0] lo;      // multiplier shifting out / quotient shifting in
  logic [XLEN-1:0] dsor;
  logic [4:0]      step;
  logic            q_neg, r_neg;
  result_t         res;

  // register reads; index 0 and indexes of NUM_REGS or more read zero
  function automatic logic [XLEN-1:0] rd(input logic [REG_IDX_W-1:0] i,
                                        input logic [XLEN-1:0] v);
    rd = (i == '0 || int'(i) >= NUM_REGS) ? '0 : v;
  endfunction

  function automatic logic [XLEN-1:0] offs(input logic [XLEN-1:0] imm);
    logic [XLEN-1:0] m;
    m = imm[XLEN-1] ? (-imm) : imm;
    m = m >> 2;
    offs = imm[XLEN-1] ? (-m) : m;
  endfunction

  // combinational execute of the simple ops
  logic [XLEN-1:0] ex_val, ex_next, opb;
  logic ex_we, ex_taken, cond, is_br;
  logic [4:0] sh;
  always_comb begin
    opb = (cur.opcode inside {OP_ADDI, OP_XORI, OP_ORI, OP_ANDI, OP_SLTI, OP_SLTIU,
                              OP_SLLI, OP_SRLI, OP_SRAI}) ? cur.immediate : b;
    sh = opb[4:0];
    ex_val = '0; ex_we = 1'b1; ex_taken = 1'b0; cond = 1'b0; is_br = 1'b0;
    ex_next = pc + 32'd1;
    case (cur.opcode)
      OP_ADD, OP_ADDI: ex_val = a + opb;
      OP_SUB: ex_val = a - b;
      OP_LUI: ex_val = cur.immediate;
      OP_AUIPC: ex_val = {pc[XLEN-3:0], 2'b00} + (cur.immediate & UPPER_MASK);
      OP_XOR, OP_XORI: ex_val = a ^ opb;
      OP_OR, OP_ORI: ex_val = a | opb;
      OP_AND, OP_ANDI: ex_val = a & opb;
      OP_SLT, OP_SLTI: ex_val = {31'd0, $signed(a) < $signed(opb)};
      OP_SLTU, OP_SLTIU: ex_val = {31'd0, a < opb};
      OP_SLL, OP_SLLI: ex_val = a << sh;
      OP_SRL, OP_SRLI: ex_val = a >> sh;
      OP_SRA, OP_SRAI: ex_val = $unsigned($signed(a) >>> sh);
      OP_BEQ: begin is_br = 1'b1; cond = a == b; end
      OP_BNE: begin is_br = 1'b1; cond = a != b; end
      OP_BLT: begin is_br = 1'b1; cond = $signed(a) < $signed(b); end
      OP_BGE: begin is_br = 1'b1; cond = $signed(a) >= $signed(b); end
      OP_BLTU: begin is_br = 1'b1; cond = a < b; end
      OP_BGEU: begin is_br = 1'b1; cond = a >= b; end
      OP_JAL: begin
        ex_val = pc + 32'd1; ex_taken = 1'b1; ex_next = pc + offs(cur.immediate);
      end
      OP_JALR: begin
        ex_val = pc + 32'd1; ex_taken = 1'b1; ex_next = a + offs(cur.immediate);
      end
      default: ex_we = 1'b0;
    endcase
    if (is_br) begin
      ex_we = 1'b0;
      if (cond) begin
        ex_taken = 1'b1;
        ex_next = pc + offs(cur.immediate);
      end
    end
  end

  // shared adder: multiply accumulate or trial subtract
  logic [XLEN:0] add_x, add_y, add_sum;
  logic add_cin;
  logic [XLEN-1:0] rem_sh;
  always_comb begin
    rem_sh = {acc[XLEN-2:0], lo[XLEN-1]};
    if (state == S_DIV) begin
      add_x   = {acc[XLEN-1], rem_sh};
      add_y   = ~{1'b0, dsor};
      add_cin = 1'b1;
    end else begin
      add_x   = {1'b0, acc};
      add_y   = lo[0] ? {1'b0, a} : '0;
      add_cin = 1'b0;
    end
    add_sum = add_x + add_y + {{XLEN{1'b0}}, add_cin};
  end

  logic is_mul, is_div, sgn_div, is_rem;
  assign is_mul  = cur.opcode inside {[OP_MUL:OP_MULHU]};
  assign is_div  = cur.opcode inside {[OP_DIV:OP_REMU]};
  assign sgn_div = cur.opcode == OP_DIV || cur.opcode == OP_REM;
  assign is_rem  = cur.opcode == OP_REM || cur.opcode == OP_REMU;

  // final result write to output register and register file
  logic [XLEN-1:0] fin_val, fin_next;
  logic fin_we, fin_taken, fin_go;
  logic [XLEN-1:0] q_fix, r_fix;
  always_comb begin
    q_fix = q_neg ? -lo : lo;
    r_fix = r_neg ? -acc : acc;
    fin_go = 1'b0; fin_val = ex_val; fin_we = ex_we; fin_next = ex_next;
    fin_taken = ex_taken;
    if (state == S_EXEC) fin_go = 1'b1;
    if (state == S_FIX) begin
      fin_go = 1'b1; fin_we = 1'b1; fin_taken = 1'b0; fin_next = pc + 32'd1;
      if (is_mul) begin
        case (cur.opcode)
          OP_MUL:    fin_val = lo;
          OP_MULH:   fin_val = acc - (a[XLEN-1] ? b : '0) - (b[XLEN-1] ? a : '0);
          OP_MULHSU: fin_val = acc - (a[XLEN-1] ? b : '0);
          default:   fin_val = acc;
        endcase
      end else if (b == '0) begin
        fin_val = is_rem ? a : '1;
      end else begin
        fin_val = is_rem ? r_fix : q_fix;
      end
    end
    if (cur.dest_reg == '0 || int'(cur.dest_reg) >= NUM_REGS) fin_we = 1'b0;
    if (!fin_we) fin_val = '0;
  end

  assign instr.ready  = state == S_IDLE;
  assign result.valid = state == S_OUT;
  assign result.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else begin
      case (state)
        S_IDLE: if (instr.valid) begin
          cur <= instr.data;
          state <= S_READ;
        end
        S_READ: begin
          a <= rd(cur.src1_reg, regs[cur.src1_reg]);
          b <= rd(cur.src2_reg, regs[cur.src2_reg]);
          step <= '0;
          state <= is_mul ? S_MUL : (is_div ? S_DIV : S_EXEC);
          acc <= '0;
          if (is_div) begin
            // operands become magnitudes for the signed forms
            lo   <= (sgn_div && regs[cur.src1_reg][XLEN-1]
                     && cur.src1_reg != '0) ? -regs[cur.src1_reg]
                    : rd(cur.src1_reg, regs[cur.src1_reg]);
            dsor <= (sgn_div && regs[cur.src2_reg][XLEN-1]
                     && cur.src2_reg != '0) ? -regs[cur.src2_reg]
                    : rd(cur.src2_reg, regs[cur.src2_reg]);
          end else begin
            lo <= rd(cur.src2_reg, regs[cur.src2_reg]);
          end
        end
        S_MUL: begin
          {acc, lo} <= {add_sum, lo[XLEN-1:1]};
          step <= step + 5'd1;
          if (step == 5'd31) state <= S_FIX;
        end
        S_DIV: begin
          if (!add_sum[XLEN]) begin
            acc <= add_sum[XLEN-1:0];
            lo  <= {lo[XLEN-2:0], 1'b1};
          end else begin
            acc <= rem_sh;
            lo  <= {lo[XLEN-2:0], 1'b0};
          end
          q_neg <= sgn_div && (a[XLEN-1] ^ b[XLEN-1]);
          r_neg <= sgn_div && a[XLEN-1];
          step <= step + 5'd1;
          if (step == 5'd31) state <= S_FIX;
        end
        S_EXEC, S_FIX: state <= S_OUT;
        S_OUT: if (result.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (fin_go) begin
        res <= '{fin_we, fin_val, fin_next, fin_taken};
        pc <= fin_next;
        if (fin_we) regs[cur.dest_reg] <= fin_val;
      end
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(instr.ready && result.valid)) else $error("ready while result pending");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |=> result.valid) else $error("result missing after fix");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !res.write_enable |-> res.write_value == '0)
    else $error("value without write");
endmodule
